/* rtl/ngga_pkg.sv */
// Shared constants, codes and elaboration helpers for the GGA sentence parser.
package ngga_pkg;

    localparam int FRACTION_DIGITS_DEF = 5;
    localparam int INTEGER_DIGITS_DEF  = 6;

    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 2;
    localparam int S_TDATA_W = 8;

    localparam int HEADER_LEN = 6;
    localparam logic [7:0] HEADER_TEXT [HEADER_LEN] = '{
        8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41
    };

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Field counter values: fields begun so far.
    localparam int FIELD_W = 3;
    localparam logic [FIELD_W-1:0] FIELD_NONE      = 3'd0;
    localparam logic [FIELD_W-1:0] FIELD_TIME      = 3'd2;
    localparam logic [FIELD_W-1:0] FIELD_LAT       = 3'd3;
    localparam logic [FIELD_W-1:0] FIELD_LAT_HEMI  = 3'd4;
    localparam logic [FIELD_W-1:0] FIELD_LON       = 3'd5;
    localparam logic [FIELD_W-1:0] FIELD_LON_HEMI  = 3'd6;
    localparam logic [FIELD_W-1:0] FIELD_COUNT_MAX = 3'd6;

    localparam int DIV_HUNDRED = 100;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_SHORT      = 2'd2
    } status_t;

    function automatic int pow10(input int n);
        int r;
        r = 1;
        for (int i = 0; i < n; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

endpackage

/* rtl/nmea_gga_time_position_parser_top.sv */
// GGA sentence parser: per-character field scan and a result pipeline.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] char_in, s_tlast frame_end
//  m_      | out | m_tvalid/m_tready  | m_tuser status, m_tdata time and positions
//
//  One item is taken every cycle while s_tready is high; its scan step is a single accumulate.
//  After the frame-end item is accepted, the result passes in order a snapshot,
//  two constant-divide stages (reciprocal multiplies) and the output register,
//  which drives m_tvalid.
//  aresetn clears the scan state and empties the result pipeline.
//  A stalled output fills the four result stages; s_tready drops only while
//  all four hold a result and m_tready is low.
module nmea_gga_time_position_parser_top #(
    parameter int FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF,
    parameter int INTEGER_DIGITS  = ngga_pkg::INTEGER_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ngga_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] char_in
    input  logic                           s_tlast,  // frame_end
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [6:0] hours, [13:7] time_minutes, [30:14] seconds_milli,
    // [44:31] lat_degrees, [51:45] lat_minutes, [67:52] lat_arcsec_milli,
    // [75:68] lat_hemisphere, [89:76] lon_degrees, [96:90] lon_minutes,
    // [112:97] lon_arcsec_milli, [120:113] lon_hemisphere, [127:121] zero
    output logic [ngga_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [ngga_pkg::M_TUSER_W-1:0] m_tuser   // [1:0] status
);
    import ngga_pkg::*;

    localparam int INT_MAX_VAL = pow10(INTEGER_DIGITS) - 1;
    localparam int INT_W  = $clog2(INT_MAX_VAL + 1);
    localparam int FRAC_W = $clog2(pow10(FRACTION_DIGITS));
    localparam int CNT_W  = $clog2(FRACTION_DIGITS + 1);
    localparam int IDX_W  = $clog2(FRACTION_DIGITS);
    localparam int Q1_W   = INT_W - 6;
    localparam int Q2_W   = Q1_W - 6;
    localparam int MS_W   = 10;
    localparam int ARC_OUT_W = 16;

    // Arc seconds: (frac * 60000 + scale/2) / scale with the common tens removed.
    localparam int ARC_MUL = (FRACTION_DIGITS <= 4) ? 6 * pow10(4 - FRACTION_DIGITS) : 6;
    localparam int ARC_ADD = (FRACTION_DIGITS <= 4) ? 0 : 5 * pow10(FRACTION_DIGITS - 5);
    localparam int ARC_DIV = (FRACTION_DIGITS <= 4) ? 1 : pow10(FRACTION_DIGITS - 4);
    localparam int ARC_W   = $clog2((pow10(FRACTION_DIGITS) - 1) * ARC_MUL + ARC_ADD + 1);
    localparam int TF_DIV  = pow10(FRACTION_DIGITS - 3);

    // Reciprocal constants: q = (x * M) >> S, exact for every x of W bits.
    localparam int DA_S = INT_W + $clog2(DIV_HUNDRED);
    localparam longint unsigned DA_M =
        ((64'd1 << DA_S) + 64'(DIV_HUNDRED - 1)) / 64'(DIV_HUNDRED);
    localparam logic [INT_W:0] DA_MUL = (INT_W + 1)'(DA_M);

    localparam int DB_S = Q1_W + $clog2(DIV_HUNDRED);
    localparam longint unsigned DB_M =
        ((64'd1 << DB_S) + 64'(DIV_HUNDRED - 1)) / 64'(DIV_HUNDRED);
    localparam logic [Q1_W:0] DB_MUL = (Q1_W + 1)'(DB_M);

    localparam int DT_S = FRAC_W + $clog2(TF_DIV);
    localparam longint unsigned DT_M = ((64'd1 << DT_S) + 64'(TF_DIV - 1)) / 64'(TF_DIV);
    localparam logic [FRAC_W:0] DT_MUL = (FRAC_W + 1)'(DT_M);

    localparam int DR_S = ARC_W + $clog2(ARC_DIV);
    localparam longint unsigned DR_M = ((64'd1 << DR_S) + 64'(ARC_DIV - 1)) / 64'(ARC_DIV);
    localparam logic [ARC_W:0] DR_MUL = (ARC_W + 1)'(DR_M);

    // ---------------- scan state ----------------
    logic [2:0]         header_pos_reg, header_pos_next;
    logic               header_bad_reg, header_bad_next;
    logic [FIELD_W-1:0] field_num_reg, field_num_next;
    logic               after_delim_reg, after_delim_next;
    logic [INT_W-1:0]   int_acc_reg, int_acc_next;
    logic [FRAC_W-1:0]  frac_acc_reg, frac_acc_next;
    logic [CNT_W-1:0]   frac_cnt_reg, frac_cnt_next;
    logic               point_reg, point_next;
    logic [INT_W-1:0]   time_int_reg, time_int_next;
    logic [FRAC_W-1:0]  time_frac_reg, time_frac_next;
    logic [INT_W-1:0]   lat_int_reg, lat_int_next;
    logic [FRAC_W-1:0]  lat_frac_reg, lat_frac_next;
    logic [INT_W-1:0]   lon_int_reg, lon_int_next;
    logic [FRAC_W-1:0]  lon_frac_reg, lon_frac_next;
    logic [7:0]         lat_hemi_reg, lat_hemi_next;
    logic [7:0]         lon_hemi_reg, lon_hemi_next;
    status_t            status_next;

    logic [FRAC_W-1:0] frac_weight [FRACTION_DIGITS];
    for (genvar gi = 0; gi < FRACTION_DIGITS; gi++) begin : g_weight
        assign frac_weight[gi] = FRAC_W'(pow10(FRACTION_DIGITS - 1 - gi));
    end

    // ---------------- result pipeline ----------------
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic               s1_ready, s2_ready, s3_ready, out_ready;
    logic               in_accept;

    status_t            s1_status_reg;
    logic [INT_W-1:0]   s1_time_int_reg, s1_lat_int_reg, s1_lon_int_reg;
    logic [FRAC_W-1:0]  s1_time_frac_reg, s1_lat_frac_reg, s1_lon_frac_reg;
    logic [7:0]         s1_lat_hemi_reg, s1_lon_hemi_reg;

    status_t            s2_status_reg;
    logic [INT_W-1:0]   s2_time_int_reg, s2_lat_int_reg, s2_lon_int_reg;
    logic [Q1_W-1:0]    s2_time_q_reg, s2_lat_q_reg, s2_lon_q_reg;
    logic [MS_W-1:0]    s2_milli_reg;
    logic [ARC_W-1:0]   s2_lat_num_reg, s2_lon_num_reg;
    logic [7:0]         s2_lat_hemi_reg, s2_lon_hemi_reg;

    status_t            s3_status_reg;
    logic [Q1_W-1:0]    s3_time_q_reg, s3_lat_q_reg, s3_lon_q_reg;
    logic [Q2_W-1:0]    s3_hours_reg;
    logic [6:0]         s3_sec_int_reg, s3_lat_min_reg, s3_lon_min_reg;
    logic [MS_W-1:0]    s3_milli_reg;
    logic [ARC_OUT_W-1:0] s3_lat_arc_reg, s3_lon_arc_reg;
    logic [7:0]         s3_lat_hemi_reg, s3_lon_hemi_reg;

    status_t            out_status_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    assign out_ready = !out_valid_reg || m_tready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // ---------------- character scan ----------------
    always_comb begin
        logic [7:0]       ch;
        logic [3:0]       digit;
        logic [INT_W+3:0] int_sum;
        logic             numeric;

        ch      = s_tdata[7:0];
        digit   = 4'(ch - CHAR_ZERO);
        int_sum = '0;
        numeric = 1'b0;

        header_pos_next  = header_pos_reg;
        header_bad_next  = header_bad_reg;
        field_num_next   = field_num_reg;
        after_delim_next = after_delim_reg;
        int_acc_next     = int_acc_reg;
        frac_acc_next    = frac_acc_reg;
        frac_cnt_next    = frac_cnt_reg;
        point_next       = point_reg;
        time_int_next    = time_int_reg;
        time_frac_next   = time_frac_reg;
        lat_int_next     = lat_int_reg;
        lat_frac_next    = lat_frac_reg;
        lon_int_next     = lon_int_reg;
        lon_frac_next    = lon_frac_reg;
        lat_hemi_next    = lat_hemi_reg;
        lon_hemi_next    = lon_hemi_reg;

        if (header_pos_reg < 3'(HEADER_LEN)) begin
            if (ch != HEADER_TEXT[header_pos_reg]) begin
                header_bad_next = 1'b1;
            end
            header_pos_next = header_pos_reg + 3'd1;
        end

        if (ch == CHAR_COMMA) begin
            after_delim_next = 1'b1;
        end else begin
            if (field_num_reg == FIELD_NONE || after_delim_reg) begin
                if (field_num_reg < FIELD_COUNT_MAX) begin
                    field_num_next = field_num_reg + FIELD_W'(1);
                    if (field_num_next == FIELD_LAT_HEMI) begin
                        lat_hemi_next = ch;
                    end
                    if (field_num_next == FIELD_LON_HEMI) begin
                        lon_hemi_next = ch;
                    end
                end
                int_acc_next  = '0;
                frac_acc_next = '0;
                frac_cnt_next = '0;
                point_next    = 1'b0;
            end
            after_delim_next = 1'b0;
            numeric = (field_num_next == FIELD_TIME) || (field_num_next == FIELD_LAT) ||
                      (field_num_next == FIELD_LON);
            if (numeric) begin
                priority if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                    if (!point_next) begin
                        int_sum = (INT_W + 4)'(int_acc_next) * (INT_W + 4)'(10) +
                                  (INT_W + 4)'(digit);
                        int_acc_next = (int_sum > (INT_W + 4)'(INT_MAX_VAL)) ?
                                       INT_W'(INT_MAX_VAL) : int_sum[INT_W-1:0];
                    end else if (frac_cnt_next < CNT_W'(FRACTION_DIGITS)) begin
                        frac_acc_next = frac_acc_next + FRAC_W'(digit) *
                                        frac_weight[frac_cnt_next[IDX_W-1:0]];
                        frac_cnt_next = frac_cnt_next + CNT_W'(1);
                    end
                end else if (ch == CHAR_POINT && !point_next) begin
                    point_next = 1'b1;
                end else begin
                    // number ended: rest of the field is ignored
                    point_next    = 1'b1;
                    frac_cnt_next = CNT_W'(FRACTION_DIGITS);
                end
                priority if (field_num_next == FIELD_TIME) begin
                    time_int_next  = int_acc_next;
                    time_frac_next = frac_acc_next;
                end else if (field_num_next == FIELD_LAT) begin
                    lat_int_next  = int_acc_next;
                    lat_frac_next = frac_acc_next;
                end else begin
                    lon_int_next  = int_acc_next;
                    lon_frac_next = frac_acc_next;
                end
            end
        end

        priority if (header_pos_next < 3'(HEADER_LEN) || header_bad_next) begin
            status_next = STATUS_BAD_HEADER;
        end else if (field_num_next < FIELD_COUNT_MAX) begin
            status_next = STATUS_SHORT;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_pos_reg  <= '0;
            header_bad_reg  <= 1'b0;
            field_num_reg   <= FIELD_NONE;
            after_delim_reg <= 1'b0;
            int_acc_reg     <= '0;
            frac_acc_reg    <= '0;
            frac_cnt_reg    <= '0;
            point_reg       <= 1'b0;
            time_int_reg    <= '0;
            time_frac_reg   <= '0;
            lat_int_reg     <= '0;
            lat_frac_reg    <= '0;
            lon_int_reg     <= '0;
            lon_frac_reg    <= '0;
            lat_hemi_reg    <= '0;
            lon_hemi_reg    <= '0;
        end else if (in_accept) begin
            if (s_tlast) begin
                header_pos_reg  <= '0;
                header_bad_reg  <= 1'b0;
                field_num_reg   <= FIELD_NONE;
                after_delim_reg <= 1'b0;
                int_acc_reg     <= '0;
                frac_acc_reg    <= '0;
                frac_cnt_reg    <= '0;
                point_reg       <= 1'b0;
                time_int_reg    <= '0;
                time_frac_reg   <= '0;
                lat_int_reg     <= '0;
                lat_frac_reg    <= '0;
                lon_int_reg     <= '0;
                lon_frac_reg    <= '0;
                lat_hemi_reg    <= '0;
                lon_hemi_reg    <= '0;
            end else begin
                header_pos_reg  <= header_pos_next;
                header_bad_reg  <= header_bad_next;
                field_num_reg   <= field_num_next;
                after_delim_reg <= after_delim_next;
                int_acc_reg     <= int_acc_next;
                frac_acc_reg    <= frac_acc_next;
                frac_cnt_reg    <= frac_cnt_next;
                point_reg       <= point_next;
                time_int_reg    <= time_int_next;
                time_frac_reg   <= time_frac_next;
                lat_int_reg     <= lat_int_next;
                lat_frac_reg    <= lat_frac_next;
                lon_int_reg     <= lon_int_next;
                lon_frac_reg    <= lon_frac_next;
                lat_hemi_reg    <= lat_hemi_next;
                lon_hemi_reg    <= lon_hemi_next;
            end
        end
    end

    // ---------------- stage 2: divide by 100, milliseconds, arc numerators ----------------
    logic [2*INT_W:0]   prod_time_q, prod_lat_q, prod_lon_q;
    logic [2*FRAC_W:0]  prod_milli;
    logic [ARC_W-1:0]   lat_num, lon_num;

    assign prod_time_q = (2*INT_W + 1)'(s1_time_int_reg) * (2*INT_W + 1)'(DA_MUL);
    assign prod_lat_q  = (2*INT_W + 1)'(s1_lat_int_reg) * (2*INT_W + 1)'(DA_MUL);
    assign prod_lon_q  = (2*INT_W + 1)'(s1_lon_int_reg) * (2*INT_W + 1)'(DA_MUL);
    assign prod_milli  = (2*FRAC_W + 1)'(s1_time_frac_reg) * (2*FRAC_W + 1)'(DT_MUL);
    assign lat_num = ARC_W'(s1_lat_frac_reg) * ARC_W'(ARC_MUL) + ARC_W'(ARC_ADD);
    assign lon_num = ARC_W'(s1_lon_frac_reg) * ARC_W'(ARC_MUL) + ARC_W'(ARC_ADD);

    // ---------------- stage 3: hours, remainders, arc seconds ----------------
    logic [2*Q1_W:0]    prod_hours;
    logic [2*ARC_W+1:0] prod_lat_arc, prod_lon_arc;
    logic [INT_W-1:0]   sec_int_full, lat_min_full, lon_min_full;

    assign prod_hours   = (2*Q1_W + 1)'(s2_time_q_reg) * (2*Q1_W + 1)'(DB_MUL);
    assign prod_lat_arc = (2*ARC_W + 2)'(s2_lat_num_reg) * (2*ARC_W + 2)'(DR_MUL);
    assign prod_lon_arc = (2*ARC_W + 2)'(s2_lon_num_reg) * (2*ARC_W + 2)'(DR_MUL);
    assign sec_int_full = s2_time_int_reg - INT_W'(s2_time_q_reg) * INT_W'(DIV_HUNDRED);
    assign lat_min_full = s2_lat_int_reg - INT_W'(s2_lat_q_reg) * INT_W'(DIV_HUNDRED);
    assign lon_min_full = s2_lon_int_reg - INT_W'(s2_lon_q_reg) * INT_W'(DIV_HUNDRED);

    // ---------------- output stage ----------------
    always_comb begin
        logic [Q1_W-1:0] min_full;
        logic [16:0]     sec_milli;

        min_full  = s3_time_q_reg - Q1_W'(s3_hours_reg) * Q1_W'(DIV_HUNDRED);
        sec_milli = 17'(s3_sec_int_reg) * 17'(1000) + 17'(s3_milli_reg);
        out_data_next = '0;
        if (s3_status_reg == STATUS_OK) begin
            out_data_next[6:0]     = 7'(s3_hours_reg);
            out_data_next[13:7]    = 7'(min_full);
            out_data_next[30:14]   = sec_milli;
            out_data_next[44:31]   = 14'(s3_lat_q_reg);
            out_data_next[51:45]   = s3_lat_min_reg;
            out_data_next[67:52]   = s3_lat_arc_reg;
            out_data_next[75:68]   = s3_lat_hemi_reg;
            out_data_next[89:76]   = 14'(s3_lon_q_reg);
            out_data_next[96:90]   = s3_lon_min_reg;
            out_data_next[112:97]  = s3_lon_arc_reg;
            out_data_next[120:113] = s3_lon_hemi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_accept && s_tlast;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && s_tlast) begin
            s1_status_reg    <= status_next;
            s1_time_int_reg  <= time_int_next;
            s1_time_frac_reg <= time_frac_next;
            s1_lat_int_reg   <= lat_int_next;
            s1_lat_frac_reg  <= lat_frac_next;
            s1_lon_int_reg   <= lon_int_next;
            s1_lon_frac_reg  <= lon_frac_next;
            s1_lat_hemi_reg  <= lat_hemi_next;
            s1_lon_hemi_reg  <= lon_hemi_next;
        end
        if (s2_ready) begin
            s2_status_reg   <= s1_status_reg;
            s2_time_int_reg <= s1_time_int_reg;
            s2_lat_int_reg  <= s1_lat_int_reg;
            s2_lon_int_reg  <= s1_lon_int_reg;
            s2_time_q_reg   <= prod_time_q[DA_S +: Q1_W];
            s2_lat_q_reg    <= prod_lat_q[DA_S +: Q1_W];
            s2_lon_q_reg    <= prod_lon_q[DA_S +: Q1_W];
            s2_milli_reg    <= prod_milli[DT_S +: MS_W];
            s2_lat_num_reg  <= lat_num;
            s2_lon_num_reg  <= lon_num;
            s2_lat_hemi_reg <= s1_lat_hemi_reg;
            s2_lon_hemi_reg <= s1_lon_hemi_reg;
        end
        if (s3_ready) begin
            s3_status_reg   <= s2_status_reg;
            s3_time_q_reg   <= s2_time_q_reg;
            s3_lat_q_reg    <= s2_lat_q_reg;
            s3_lon_q_reg    <= s2_lon_q_reg;
            s3_hours_reg    <= prod_hours[DB_S +: Q2_W];
            s3_sec_int_reg  <= sec_int_full[6:0];
            s3_lat_min_reg  <= lat_min_full[6:0];
            s3_lon_min_reg  <= lon_min_full[6:0];
            s3_milli_reg    <= s2_milli_reg;
            s3_lat_arc_reg  <= prod_lat_arc[DR_S +: ARC_OUT_W];
            s3_lon_arc_reg  <= prod_lon_arc[DR_S +: ARC_OUT_W];
            s3_lat_hemi_reg <= s2_lat_hemi_reg;
            s3_lon_hemi_reg <= s2_lon_hemi_reg;
        end
        if (out_ready) begin
            out_status_reg <= s3_status_reg;
            out_data_reg   <= out_data_next;
        end
    end

endmodule

/* rtl/ngga_checker.sv */
// Port-level checks for the GGA sentence parser, bound to the top level.
module ngga_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ngga_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ngga_pkg::M_TUSER_W-1:0] m_tuser
);
    import ngga_pkg::*;

    // reset empties the result pipeline and opens the input
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // a draining output never blocks the character stream
    a_no_block_when_draining : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is taken");

    // a held result keeps its payload
    a_out_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

endmodule

bind nmea_gga_time_position_parser_top ngga_checker u_ngga_checker (.*);
